FILE: rtl/core/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// Shared constants, codes and controller/datapath structs for the GIF LZW
// code decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

    // Default sizing
    localparam int MAX_CODE_BITS = 12;
    localparam int STACK_DEPTH   = 8192;
    localparam int ACCUM_BITS    = 32;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int PIX_W    = 11;
    localparam int MIN_W    = 4;
    localparam int EPOCH_W  = 8;

    // Register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [MIN_W-1:0] MIN_CODE_RESET = 4'd8;
    localparam logic [APB_ADDR_W-3:0] REG_MIN_CODE_SIZE = '0;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_FEED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_PIXEL    = 3'd1,
        ST_NEED     = 3'd2,
        ST_END      = 3'd3,
        ST_CORRUPT  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PIX_ZERO,
        PIX_CODE,
        PIX_STACK,
        PIX_SUFFIX
    } t_pix_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POPD,
        S_DECODE,
        S_CLEAR,
        S_SWEEP,
        S_TAKE,
        S_CHAIN,
        S_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     feed;
        logic     start;
        logic     pop;
        logic     rebuild;
        logic     sweep_step;
        logic     take;
        logic     set_root;
        logic     set_pending;
        logic     set_finished;
        logic     walk_begin;
        logic     walk_step;
        logic     final_step;
        logic     clear_stack;
        logic     res_load;
        t_status  res_status;
        t_pix_src res_pix;
        logic     emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic acc_full;
        logic stack_nonempty;
        logic finished;
        logic pending;
        logic clr_ok;
        logic epoch_max;
        logic sweep_last;
        logic code_ok;
        logic code_clr;
        logic code_end;
        logic code_gt_clr;
        logic cur_ge_clr;
        logic self_loop;
        logic stack_full_next;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/gld_in_if.sv
// ----------------------------------------------------------------------------
// gld_in_if
// Input word channel: kind and payload byte with valid/ready.
// ----------------------------------------------------------------------------
interface gld_in_if;
    logic                        valid;
    logic                        ready;
    logic [gld_pkg::KIND_W-1:0]  kind;
    logic [gld_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

FILE: rtl/core/gld_out_if.sv
// ----------------------------------------------------------------------------
// gld_out_if
// Result word channel: status and pixel index with valid/ready.
// ----------------------------------------------------------------------------
interface gld_out_if;
    logic                          valid;
    logic                          ready;
    logic [gld_pkg::STATUS_W-1:0]  status;
    logic [gld_pkg::PIX_W-1:0]     pixel_index;

    modport source (output valid, output status, output pixel_index, input ready);
    modport sink   (input valid, input status, input pixel_index, output ready);
endinterface

FILE: rtl/core/gif_lzw_code_decoder_top.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_decoder_top
// Variable-width LZW decoder for GIF pixel data, one status/pixel word out
// for every word in.
// ----------------------------------------------------------------------------
// Each word passes through dispatch and a registered result hand-off. A read
// that pops the output stack adds one registered stack read; a read that
// unpacks a code takes the code and walks its prefix chain, each link being
// one registered read of the code table and one stack push. Each clear code
// met in the stream adds a table rebuild and a further code take. The first
// rebuild after reset and every 255th one after it add a sweep over all
// 2^MAX_CODE_BITS table entries that wipes stale table tags. The next word is
// accepted while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module gif_lzw_code_decoder_top #(
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS,
    parameter int STACK_DEPTH   = gld_pkg::STACK_DEPTH,
    parameter int ACCUM_BITS    = gld_pkg::ACCUM_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gld_in_if.sink                          i_in,
    gld_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gld_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gld_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    gld_pkg::t_cmd w_cmd;
    gld_pkg::t_sts w_sts;
    logic          w_cfg_wr;

    // Register writes complete in the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    gld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gld_dp #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .STACK_DEPTH   (STACK_DEPTH),
        .ACCUM_BITS    (ACCUM_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_in.kind),
        .i_data_byte   (i_in.data_byte),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_status      (o_out.status),
        .o_pixel_index (o_out.pixel_index),
        .i_cfg_wr      (w_cfg_wr),
        .i_cfg_addr    (paddr),
        .i_cfg_wdata   (pwdata),
        .o_cfg_rdata   (prdata)
    );

endmodule

FILE: rtl/core/gld_ctrl.sv
// ----------------------------------------------------------------------------
// gld_ctrl
// Decoder sequencer: steps one word at a time through dispatch, stack pop,
// clear, sweep, code take, chain walk and result hand-off.
// ----------------------------------------------------------------------------
module gld_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gld_pkg::t_sts i_sts,
    output gld_pkg::t_cmd o_cmd
);

    gld_pkg::t_state r_state;
    gld_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gld_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gld_pkg::S_IDLE: begin
                if (i_in_valid) n_state = gld_pkg::S_DISPATCH;
            end
            gld_pkg::S_DISPATCH: begin
                n_state = gld_pkg::S_RESP;
                if (i_sts.kind == gld_pkg::KIND_READ) begin
                    if (i_sts.stack_nonempty) n_state = gld_pkg::S_POPD;
                    else if (!i_sts.finished) n_state = gld_pkg::S_DECODE;
                end
            end
            gld_pkg::S_POPD: n_state = gld_pkg::S_RESP;
            gld_pkg::S_DECODE: begin
                if (!i_sts.pending) n_state = gld_pkg::S_TAKE;
                else if (i_sts.clr_ok) n_state = gld_pkg::S_CLEAR;
                else n_state = gld_pkg::S_RESP;
            end
            gld_pkg::S_CLEAR: begin
                n_state = i_sts.epoch_max ? gld_pkg::S_SWEEP : gld_pkg::S_TAKE;
            end
            gld_pkg::S_SWEEP: begin
                if (i_sts.sweep_last) n_state = gld_pkg::S_TAKE;
            end
            gld_pkg::S_TAKE: begin
                if (!i_sts.code_ok) n_state = gld_pkg::S_RESP;
                else if (i_sts.code_clr) n_state = gld_pkg::S_CLEAR;
                else if (!i_sts.pending && !i_sts.code_end) n_state = gld_pkg::S_CHAIN;
                else n_state = gld_pkg::S_RESP;
            end
            gld_pkg::S_CHAIN: begin
                if (!i_sts.cur_ge_clr || i_sts.self_loop || i_sts.stack_full_next) begin
                    n_state = gld_pkg::S_RESP;
                end
            end
            gld_pkg::S_RESP: begin
                if (i_sts.out_free) n_state = gld_pkg::S_IDLE;
            end
            default: n_state = gld_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.res_status = gld_pkg::ST_ACCEPTED;
        o_cmd.res_pix = gld_pkg::PIX_ZERO;
        o_in_ready = 1'b0;
        case (r_state)
            gld_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            gld_pkg::S_DISPATCH: begin
                case (i_sts.kind)
                    gld_pkg::KIND_FEED: begin
                        o_cmd.res_load = 1'b1;
                        if (i_sts.acc_full) begin
                            o_cmd.res_status = gld_pkg::ST_OVERFLOW;
                        end else begin
                            o_cmd.feed = 1'b1;
                        end
                    end
                    gld_pkg::KIND_READ: begin
                        if (i_sts.stack_nonempty) begin
                            o_cmd.pop = 1'b1;
                        end else if (i_sts.finished) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_status = gld_pkg::ST_END;
                        end
                    end
                    gld_pkg::KIND_START: begin
                        o_cmd.start = 1'b1;
                        o_cmd.res_load = 1'b1;
                    end
                    default: o_cmd.res_load = 1'b1;
                endcase
            end
            gld_pkg::S_POPD: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_status = gld_pkg::ST_PIXEL;
                o_cmd.res_pix = gld_pkg::PIX_STACK;
            end
            gld_pkg::S_DECODE: begin
                if (i_sts.pending && !i_sts.clr_ok) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_status = gld_pkg::ST_CORRUPT;
                end
            end
            gld_pkg::S_CLEAR: o_cmd.rebuild = 1'b1;
            gld_pkg::S_SWEEP: o_cmd.sweep_step = 1'b1;
            gld_pkg::S_TAKE: begin
                if (!i_sts.code_ok) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_status = gld_pkg::ST_NEED;
                end else begin
                    o_cmd.take = 1'b1;
                    if (i_sts.code_clr) begin
                        o_cmd.set_pending = 1'b1;
                    end else if (i_sts.code_end) begin
                        o_cmd.set_finished = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_status = gld_pkg::ST_END;
                    end else if (i_sts.pending) begin
                        o_cmd.res_load = 1'b1;
                        if (i_sts.code_gt_clr) begin
                            o_cmd.res_status = gld_pkg::ST_CORRUPT;
                        end else begin
                            o_cmd.set_root = 1'b1;
                            o_cmd.res_status = gld_pkg::ST_PIXEL;
                            o_cmd.res_pix = gld_pkg::PIX_CODE;
                        end
                    end else begin
                        o_cmd.walk_begin = 1'b1;
                    end
                end
            end
            gld_pkg::S_CHAIN: begin
                if (i_sts.cur_ge_clr) begin
                    o_cmd.walk_step = 1'b1;
                    if (i_sts.self_loop) begin
                        o_cmd.clear_stack = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_status = gld_pkg::ST_CORRUPT;
                    end else if (i_sts.stack_full_next) begin
                        o_cmd.clear_stack = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_status = gld_pkg::ST_OVERFLOW;
                    end
                end else begin
                    o_cmd.final_step = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_status = gld_pkg::ST_PIXEL;
                    o_cmd.res_pix = gld_pkg::PIX_SUFFIX;
                end
            end
            gld_pkg::S_RESP: o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/gld_dp.sv
// ----------------------------------------------------------------------------
// gld_dp
// Decoder datapath: bit accumulator, code tables with epoch tags, output
// stack, register port and result register.
// ----------------------------------------------------------------------------
module gld_dp #(
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS,
    parameter int STACK_DEPTH   = gld_pkg::STACK_DEPTH,
    parameter int ACCUM_BITS    = gld_pkg::ACCUM_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gld_pkg::t_cmd                     i_cmd,
    output gld_pkg::t_sts                     o_sts,
    input  logic [gld_pkg::KIND_W-1:0]        i_kind,
    input  logic [gld_pkg::BYTE_W-1:0]        i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [gld_pkg::STATUS_W-1:0]      o_status,
    output logic [gld_pkg::PIX_W-1:0]         o_pixel_index,
    input  logic                              i_cfg_wr,
    input  logic [gld_pkg::APB_ADDR_W-1:0]    i_cfg_addr,
    input  logic [gld_pkg::APB_DATA_W-1:0]    i_cfg_wdata,
    output logic [gld_pkg::APB_DATA_W-1:0]    o_cfg_rdata
);

    localparam int TW   = MAX_CODE_BITS;
    localparam int NW   = TW + 1;
    localparam int CWW  = $clog2(TW + 1);
    localparam int BCW  = $clog2(ACCUM_BITS + 1);
    localparam int SCW  = $clog2(STACK_DEPTH + 1);
    localparam int SIW  = $clog2(STACK_DEPTH);
    localparam int PW   = gld_pkg::PIX_W;
    localparam int EW   = gld_pkg::EPOCH_W;
    localparam int MEW  = EW + TW + PW;
    localparam int TABLE_SIZE = 1 << TW;

    logic [gld_pkg::MIN_W-1:0]  r_min;
    logic [gld_pkg::KIND_W-1:0] r_kind;
    logic [gld_pkg::BYTE_W-1:0] r_byte;
    logic [ACCUM_BITS-1:0]      r_acc;
    logic [BCW-1:0]             r_bits;
    logic [CWW-1:0]             r_cw;
    logic [NW-1:0]              r_nfc;
    logic [NW-1:0]              r_wl;
    logic [PW-1:0]              r_first;
    logic [TW-1:0]              r_prev;
    logic [TW-1:0]              r_incode;
    logic [TW-1:0]              r_cur;
    logic [TW-1:0]              r_clr_reb;
    logic                       r_pending;
    logic                       r_finished;
    logic [SCW-1:0]             r_cnt;
    logic [EW-1:0]              r_epoch;
    logic [TW-1:0]              r_sweep;
    logic [MEW-1:0]             r_tab_rd;
    logic [PW-1:0]              r_stk_rd;
    gld_pkg::t_status           r_res_status;
    logic [PW-1:0]              r_res_pix;
    logic                       r_out_valid;
    logic [gld_pkg::STATUS_W-1:0] r_out_status;
    logic [PW-1:0]              r_out_pix;

    logic [MEW-1:0] r_table [TABLE_SIZE];
    logic [PW-1:0]  r_stack [STACK_DEPTH];

    logic            w_clr_ok;
    logic [TW-1:0]   w_clr;
    logic [TW-1:0]   w_code;
    logic            w_code_ok;
    logic [TW-1:0]   w_begin_cur;
    logic            w_begin_push;
    logic            w_ent_valid;
    logic [TW-1:0]   w_pre_eff;
    logic [PW-1:0]   w_suf_eff;
    logic [TW-1:0]   w_tab_raddr;
    logic            w_tab_we;
    logic [TW-1:0]   w_tab_waddr;
    logic [MEW-1:0]  w_tab_wdata;
    logic            w_stk_we;
    logic [PW-1:0]   w_stk_wdata;
    logic [SIW-1:0]  w_stk_raddr;
    logic [NW-1:0]   w_tab_size;
    logic [NW-1:0]   w_nfc_inc;
    logic            w_cfg_sel;
    logic [PW-1:0]   w_res_pix;

    // Live clear code from the root size
    assign w_clr_ok = (int'(r_min) < MAX_CODE_BITS);
    assign w_clr    = w_clr_ok ? (TW'(1) << r_min) : '0;
    assign w_tab_size = NW'(TABLE_SIZE);
    assign w_nfc_inc  = r_nfc + NW'(1);

    // Next code from the low end of the accumulator
    assign w_code    = r_acc[TW-1:0] & ~({TW{1'b1}} << r_cw);
    assign w_code_ok = (r_bits >= BCW'(r_cw));

    // Chain start: codes not yet in the table restart from the previous code
    assign w_begin_push = ({1'b0, w_code} >= r_nfc);
    assign w_begin_cur  = w_begin_push ? r_prev : w_code;

    // Table entry as seen under the current epoch
    assign w_ent_valid = (r_tab_rd[MEW-1 -: EW] == r_epoch);
    assign w_pre_eff   = w_ent_valid ? r_tab_rd[PW +: TW] : '0;
    assign w_suf_eff   = w_ent_valid ? r_tab_rd[PW-1:0] :
                         ((r_cur < r_clr_reb) ? PW'(r_cur) : '0);

    // Table ports
    assign w_tab_raddr = i_cmd.walk_step  ? w_pre_eff :
                         i_cmd.walk_begin ? w_begin_cur : r_cur;
    assign w_tab_we    = i_cmd.sweep_step || (i_cmd.final_step && (r_nfc < w_tab_size));
    assign w_tab_waddr = i_cmd.sweep_step ? r_sweep : r_nfc[TW-1:0];
    assign w_tab_wdata = i_cmd.sweep_step ? '0 : {r_epoch, r_prev, w_suf_eff};

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_table[w_tab_waddr] <= w_tab_wdata;
        end
        r_tab_rd <= r_table[w_tab_raddr];
    end

    // Stack ports
    assign w_stk_we    = (i_cmd.walk_begin && w_begin_push) || i_cmd.walk_step;
    assign w_stk_wdata = i_cmd.walk_step ? w_suf_eff : r_first;
    assign w_stk_raddr = SIW'(r_cnt - SCW'(1));

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack[r_cnt[SIW-1:0]] <= w_stk_wdata;
        end
        r_stk_rd <= r_stack[w_stk_raddr];
    end

    // Register port
    assign w_cfg_sel   = (i_cfg_addr[gld_pkg::APB_ADDR_W-1:2] == gld_pkg::REG_MIN_CODE_SIZE);
    assign o_cfg_rdata = w_cfg_sel ? gld_pkg::APB_DATA_W'(r_min) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= gld_pkg::MIN_CODE_RESET;
        end else if (i_cfg_wr && w_cfg_sel) begin
            r_min <= i_cfg_wdata[gld_pkg::MIN_W-1:0];
        end
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_byte <= i_data_byte;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_bits     <= '0;
            r_cw       <= CWW'(gld_pkg::MIN_CODE_RESET) + CWW'(1);
            r_nfc      <= '0;
            r_wl       <= '0;
            r_first    <= '0;
            r_prev     <= '0;
            r_pending  <= 1'b1;
            r_finished <= 1'b0;
            r_cnt      <= '0;
            r_epoch    <= '1;
            r_sweep    <= '0;
        end else begin
            // Accumulator
            if (i_cmd.start) begin
                r_acc  <= '0;
                r_bits <= '0;
            end else if (i_cmd.feed) begin
                r_acc  <= r_acc | (ACCUM_BITS'(r_byte) << r_bits);
                r_bits <= r_bits + BCW'(8);
            end else if (i_cmd.take) begin
                r_acc  <= r_acc >> r_cw;
                r_bits <= r_bits - BCW'(r_cw);
            end

            // Decode flags
            if (i_cmd.start || i_cmd.set_pending) r_pending <= 1'b1;
            else if (i_cmd.set_root) r_pending <= 1'b0;
            if (i_cmd.start) r_finished <= 1'b0;
            else if (i_cmd.set_finished) r_finished <= 1'b1;

            // Previous and first codes
            if (i_cmd.start) begin
                r_first <= '0;
                r_prev  <= '0;
            end else if (i_cmd.set_root) begin
                r_first <= PW'(w_code);
                r_prev  <= w_code;
            end else if (i_cmd.final_step) begin
                r_first <= w_suf_eff;
                r_prev  <= r_incode;
            end

            // Widths and next free slot
            if (i_cmd.rebuild) begin
                r_cw  <= CWW'({1'b0, r_min} + 5'd1);
                r_wl  <= {w_clr, 1'b0};
                r_nfc <= {1'b0, w_clr} + NW'(2);
            end else if (i_cmd.final_step && (r_nfc < w_tab_size)) begin
                r_nfc <= w_nfc_inc;
                if ((w_nfc_inc >= r_wl) && (r_wl < w_tab_size)) begin
                    r_wl <= r_wl << 1;
                    r_cw <= r_cw + CWW'(1);
                end
            end

            // Stack depth
            if (i_cmd.start || i_cmd.rebuild || i_cmd.clear_stack) begin
                r_cnt <= '0;
            end else if (i_cmd.pop) begin
                r_cnt <= r_cnt - SCW'(1);
            end else if (w_stk_we) begin
                r_cnt <= r_cnt + SCW'(1);
            end

            // Table epoch and clearing sweep
            if (i_cmd.rebuild) begin
                r_sweep <= '0;
                if (!(&r_epoch)) r_epoch <= r_epoch + EW'(1);
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + TW'(1);
                if (&r_sweep) r_epoch <= EW'(1);
            end
        end
    end

    // Chain cursor
    always_ff @(posedge i_clk) begin
        if (i_cmd.rebuild) begin
            r_clr_reb <= w_clr;
        end
        if (i_cmd.walk_begin) begin
            r_incode <= w_code;
            r_cur    <= w_begin_cur;
        end else if (i_cmd.walk_step) begin
            r_cur <= w_pre_eff;
        end
    end

    // Result hold and output register
    always_comb begin
        case (i_cmd.res_pix)
            gld_pkg::PIX_CODE:   w_res_pix = PW'(w_code);
            gld_pkg::PIX_STACK:  w_res_pix = r_stk_rd;
            gld_pkg::PIX_SUFFIX: w_res_pix = w_suf_eff;
            default:             w_res_pix = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_pix    <= w_res_pix;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_pix    <= r_res_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_pixel_index = r_out_pix;

    // Status to the sequencer
    always_comb begin
        o_sts.kind            = r_kind;
        o_sts.acc_full        = ({1'b0, r_bits} + (BCW+1)'(8)) > (BCW+1)'(ACCUM_BITS);
        o_sts.stack_nonempty  = (r_cnt != '0);
        o_sts.finished        = r_finished;
        o_sts.pending         = r_pending;
        o_sts.clr_ok          = w_clr_ok;
        o_sts.epoch_max       = &r_epoch;
        o_sts.sweep_last      = &r_sweep;
        o_sts.code_ok         = w_code_ok;
        o_sts.code_clr        = w_clr_ok && (w_code == w_clr);
        o_sts.code_end        = w_clr_ok && (w_code == (w_clr + TW'(1)));
        o_sts.code_gt_clr     = w_clr_ok && (w_code > w_clr);
        o_sts.cur_ge_clr      = w_clr_ok && (r_cur >= w_clr);
        o_sts.self_loop       = (w_pre_eff == r_cur);
        o_sts.stack_full_next = ((r_cnt + SCW'(1)) >= SCW'(STACK_DEPTH));
        o_sts.out_free        = !r_out_valid || i_out_ready;
    end

endmodule

FILE: rtl/core/gld_checker.sv
// ----------------------------------------------------------------------------
// gld_checker
// Port-level checks for the decoder: result count against accepted words,
// idle result encoding and output hold under back-pressure.
// ----------------------------------------------------------------------------
module gld_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [gld_pkg::STATUS_W-1:0]    i_status,
    input logic [gld_pkg::PIX_W-1:0]       i_pixel_index,
    input logic                            i_pready
);

    logic [2:0] r_open;
    logic [2:0] n_open;

    // Count words accepted but not yet answered
    always_comb begin
        n_open = r_open;
        if (i_in_valid && i_in_ready) n_open = n_open + 3'd1;
        if (i_out_valid && i_out_ready) n_open = n_open - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= n_open;
        end
    end

    // No result without a word behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_open != 3'd0))
        else $error("result shown with no word outstanding");

    // At most one word in flight plus one result waiting
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 3'd2)
        else $error("too many words outstanding");

    // Non-pixel results carry a zero index
    a_zero_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != 3'(gld_pkg::ST_PIXEL))) |-> (i_pixel_index == '0))
        else $error("index set on a non-pixel result");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_pixel_index)))
        else $error("stalled result changed");

    // Register port never stalls
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready dropped");

endmodule

bind gif_lzw_code_decoder_top gld_checker u_gld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_pixel_index (o_out.pixel_index),
    .i_pready      (pready)
);

FILE: tb/gif_lzw_code_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_decoder_top_tb
// Self-checking bench for the GIF LZW code decoder. Code streams are packed
// LSB-first into payload bytes, fed in and read back pixel by pixel. An
// in-bench decoder predicts every status/pixel word, and the result channel
// is compared word by word. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module gif_lzw_code_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_N     = 1 << gld_pkg::MAX_CODE_BITS;
    localparam int STK_N       = gld_pkg::STACK_DEPTH;
    localparam int ACC_N       = gld_pkg::ACCUM_BITS;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        gld_pkg::t_status status;
        logic [10:0]      pixel;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [gld_pkg::APB_ADDR_W-1:0] paddr;
    logic [gld_pkg::APB_DATA_W-1:0] pwdata;
    logic [gld_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    gld_in_if  in_if();
    gld_out_if out_if();

    gif_lzw_code_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Decoder shadow state
    int unsigned      lzw_min;
    logic [11:0]      lzw_prefix [TABLE_N];
    logic [10:0]      lzw_suffix [TABLE_N];
    logic [11:0]      lzw_stack  [STK_N];
    int unsigned      lzw_depth;
    logic [31:0]      lzw_acc;
    int unsigned      lzw_bits;
    int unsigned      lzw_width;
    int unsigned      lzw_next;
    int unsigned      lzw_limit;
    int unsigned      lzw_first;
    int unsigned      lzw_prev;
    bit               lzw_pending;
    bit               lzw_done;

    t_decoded         decoded_q[$];
    logic [7:0]       payload_q[$];
    int               errors;
    int               words_sent;
    int               cycles;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_req;
    int               hold_ack;
    int               hold_left;

    // Stream packer state
    int unsigned      pk_width, pk_next, pk_limit, pk_clr, pk_bits;
    logic [63:0]      pk_acc;
    bit               pk_first;

    function automatic void lzw_restart();
        int unsigned clr;
        clr = 1 << (lzw_min & 15);
        lzw_width = (lzw_min & 15) + 1;
        lzw_limit = 2 * clr;
        lzw_next  = clr + 2;
        lzw_depth = 0;
    endfunction

    function automatic void lzw_rebuild();
        int unsigned clr;
        clr = 1 << (lzw_min & 15);
        for (int i = 0; i < TABLE_N; i++) begin
            lzw_prefix[i] = '0;
            lzw_suffix[i] = (i < clr) ? 11'(i) : '0;
        end
        lzw_restart();
    endfunction

    function automatic void lzw_start();
        lzw_acc = '0;
        lzw_bits = 0;
        lzw_first = 0;
        lzw_prev = 0;
        lzw_pending = 1'b1;
        lzw_done = 1'b0;
        lzw_restart();
    endfunction

    function automatic bit lzw_take(output int unsigned code);
        code = 0;
        if (lzw_width == 0 || lzw_width > 16 || lzw_bits < lzw_width) return 1'b0;
        code = lzw_acc & ((32'd1 << lzw_width) - 1);
        lzw_acc = lzw_acc >> lzw_width;
        lzw_bits -= lzw_width;
        return 1'b1;
    endfunction

    function automatic void lzw_push(int unsigned v);
        if (lzw_depth < STK_N) begin
            lzw_stack[lzw_depth] = 12'(v);
            lzw_depth++;
        end
    endfunction

    // Pop the stack or unpack the next code
    function automatic void lzw_read(output gld_pkg::t_status st,
                                     output logic [10:0] px);
        int unsigned clr, endc, code, incode;
        st = gld_pkg::ST_PIXEL;
        px = '0;
        if (lzw_depth > 0) begin
            lzw_depth--;
            px = lzw_stack[lzw_depth][10:0];
            return;
        end
        if (lzw_done) begin
            st = gld_pkg::ST_END;
            return;
        end
        clr = 1 << (lzw_min & 15);
        endc = clr + 1;
        forever begin
            if (lzw_pending) begin
                if (clr >= TABLE_N) begin
                    st = gld_pkg::ST_CORRUPT;
                    return;
                end
                lzw_rebuild();
                if (!lzw_take(code)) begin
                    st = gld_pkg::ST_NEED;
                    return;
                end
                if (code == clr) continue;
                if (code == endc) begin
                    lzw_done = 1'b1;
                    st = gld_pkg::ST_END;
                    return;
                end
                if (code > clr) begin
                    st = gld_pkg::ST_CORRUPT;
                    return;
                end
                lzw_first = code;
                lzw_prev = code;
                lzw_pending = 1'b0;
                px = 11'(code);
                return;
            end
            if (!lzw_take(code)) begin
                st = gld_pkg::ST_NEED;
                return;
            end
            if (code == clr) begin
                lzw_pending = 1'b1;
                continue;
            end
            if (code == endc) begin
                lzw_done = 1'b1;
                st = gld_pkg::ST_END;
                return;
            end
            break;
        end
        incode = code;
        if (code >= lzw_next) begin
            lzw_push(lzw_first);
            code = lzw_prev;
        end
        // Walk the prefix chain
        while (code >= clr) begin
            code &= TABLE_N - 1;
            lzw_push(lzw_suffix[code]);
            if (lzw_prefix[code] == code) begin
                lzw_depth = 0;
                st = gld_pkg::ST_CORRUPT;
                return;
            end
            if (lzw_depth >= STK_N) begin
                lzw_depth = 0;
                st = gld_pkg::ST_OVERFLOW;
                return;
            end
            code = lzw_prefix[code];
        end
        code &= TABLE_N - 1;
        lzw_first = lzw_suffix[code];
        lzw_push(lzw_first);
        if (lzw_next < TABLE_N) begin
            lzw_prefix[lzw_next] = 12'(lzw_prev);
            lzw_suffix[lzw_next] = 11'(lzw_first);
            lzw_next++;
            if (lzw_next >= lzw_limit && lzw_limit < TABLE_N) begin
                lzw_limit *= 2;
                lzw_width++;
            end
        end
        lzw_prev = incode;
        lzw_depth--;
        px = lzw_stack[lzw_depth][10:0];
    endfunction

    function automatic t_decoded lzw_predict(logic [1:0] kind, logic [7:0] data);
        t_decoded d;
        d.status = gld_pkg::ST_ACCEPTED;
        d.pixel = '0;
        if (kind == gld_pkg::KIND_FEED) begin
            if (lzw_bits + 8 > ACC_N) begin
                d.status = gld_pkg::ST_OVERFLOW;
            end else begin
                lzw_acc |= 32'(data) << lzw_bits;
                lzw_bits += 8;
            end
        end else if (kind == gld_pkg::KIND_READ) begin
            lzw_read(d.status, d.pixel);
        end else if (kind == gld_pkg::KIND_START) begin
            lzw_start();
        end
        return d;
    endfunction

    // Offer one word, hold it until accepted; called and returns at a falling edge
    task automatic send_word(input logic [1:0] kind, input logic [7:0] data,
                             output gld_pkg::t_status st);
        t_decoded d;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind <= kind;
        in_if.data_byte <= data;
        do @(posedge i_clk); while (!in_if.ready);
        d = lzw_predict(kind, data);
        decoded_q.push_back(d);
        st = d.status;
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_and_drain();
        in_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_min_code(input int unsigned v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {gld_pkg::REG_MIN_CODE_SIZE, 2'b00};
        pwdata <= gld_pkg::APB_DATA_W'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        lzw_min = v & 15;
        // Read back
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[gld_pkg::MIN_W-1:0] !== gld_pkg::MIN_W'(v)) begin
            $display("%0t readback min_code_size: expected %0d actual %0d",
                     $time, v, prdata[gld_pkg::MIN_W-1:0]);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Code packer, tracking the width the decoder will use
    function automatic void pack_begin();
        payload_q.delete();
        pk_clr = 1 << lzw_min;
        pk_width = lzw_min + 1;
        pk_next = pk_clr + 2;
        pk_limit = 2 * pk_clr;
        pk_first = 1'b1;
        pk_acc = '0;
        pk_bits = 0;
    endfunction

    function automatic void pack_code(int unsigned c);
        pk_acc |= 64'(c & ((1 << pk_width) - 1)) << pk_bits;
        pk_bits += pk_width;
        while (pk_bits >= 8) begin
            payload_q.push_back(pk_acc[7:0]);
            pk_acc >>= 8;
            pk_bits -= 8;
        end
        if (c == pk_clr) begin
            pk_width = lzw_min + 1;
            pk_next = pk_clr + 2;
            pk_limit = 2 * pk_clr;
            pk_first = 1'b1;
        end else if (pk_first) begin
            if (c < pk_clr) pk_first = 1'b0;
        end else if (pk_next < TABLE_N) begin
            pk_next++;
            if (pk_next >= pk_limit && pk_limit < TABLE_N) begin
                pk_limit *= 2;
                pk_width++;
            end
        end
    endfunction

    function automatic void pack_end();
        if (pk_bits > 0) payload_q.push_back(pk_acc[7:0]);
    endfunction

    // Feed the packed stream and read pixels until the end code
    task automatic play_stream(input bit noisy);
        gld_pkg::t_status st;
        int steps;
        steps = 0;
        send_word(gld_pkg::KIND_START, 8'($urandom), st);
        while (steps < 30000) begin
            steps++;
            if (noisy && $urandom_range(99) < 4) begin
                send_word(2'($urandom), 8'($urandom), st);
            end else if (payload_q.size() > 0 && lzw_bits + 8 <= ACC_N &&
                         (lzw_bits < lzw_width || $urandom_range(2) == 0)) begin
                send_word(gld_pkg::KIND_FEED, payload_q.pop_front(), st);
            end else begin
                send_word(gld_pkg::KIND_READ, 8'($urandom), st);
                if (st == gld_pkg::ST_END) break;
                if (st == gld_pkg::ST_NEED && payload_q.size() == 0) break;
            end
        end
    endtask

    // Random image: mostly valid codes, optionally with codes past the table
    task automatic run_image(input bit noisy, input int n_codes, input int root_pct);
        int unsigned c, top;
        pack_begin();
        pack_code(pk_clr);
        for (int i = 0; i < n_codes; i++) begin
            top = (pk_next < TABLE_N) ? pk_next : TABLE_N - 1;
            if (!pk_first && $urandom_range(99) < 2) begin
                c = pk_clr;
            end else if (pk_first || $urandom_range(99) < root_pct || top < pk_clr + 2) begin
                c = $urandom_range(pk_clr - 1);
            end else begin
                c = $urandom_range(top, pk_clr + 2);
            end
            if (noisy && $urandom_range(99) < 5) c = pk_next + $urandom_range(3);
            pack_code(c);
        end
        pack_code(pk_clr + 1);
        pack_end();
        play_stream(noisy);
    endtask

    task automatic test_directed();
        gld_pkg::t_status st;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(gld_pkg::KIND_READ, 8'h00, st);
        send_word(2'd3, 8'hff, st);
        send_word(gld_pkg::KIND_FEED, 8'h00, st);
        send_word(gld_pkg::KIND_FEED, 8'hff, st);
        send_word(gld_pkg::KIND_FEED, 8'hff, st);
        send_word(gld_pkg::KIND_FEED, 8'hff, st);
        send_word(gld_pkg::KIND_FEED, 8'hff, st);
        send_word(gld_pkg::KIND_READ, 8'h00, st);
        // Double clear, first-code rule, mid-stream clear, bad first code
        pack_begin();
        pack_code(256);
        pack_code(256);
        pack_code(65);
        pack_code(258);
        pack_code(66);
        pack_code(260);
        pack_code(256);
        pack_code(300);
        pack_code(7);
        pack_code(255);
        pack_code(257);
        pack_end();
        play_stream(1'b0);
        send_word(gld_pkg::KIND_READ, 8'h00, st);
        send_word(gld_pkg::KIND_FEED, 8'ha5, st);
        send_word(gld_pkg::KIND_START, 8'h5a, st);
        idle_and_drain();
    endtask

    // Tiny root sizes and ones outside the usable range, then sizes 2 and 11
    task automatic test_root_sizes();
        gld_pkg::t_status st;
        int unsigned sizes[4] = '{0, 1, 12, 15};
        foreach (sizes[i]) begin
            write_min_code(sizes[i]);
            send_word(gld_pkg::KIND_START, 8'h00, st);
            repeat (2) send_word(gld_pkg::KIND_FEED, 8'($urandom), st);
            repeat (3) send_word(gld_pkg::KIND_READ, 8'h00, st);
            idle_and_drain();
        end
        write_min_code(2);
        run_image(1'b0, 40, 50);
        idle_and_drain();
        write_min_code(11);
        run_image(1'b0, 30, 50);
        idle_and_drain();
    endtask

    task automatic test_random();
        int target;
        for (int ch = 0; ch < 8; ch++) begin
            write_min_code(($urandom_range(4) == 0) ? 11 : $urandom_range(8, 2));
            case (ch % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            target = words_sent + 250;
            while (words_sent < target)
                run_image($urandom_range(3) == 0, $urandom_range(60, 5), 50);
            idle_and_drain();
        end
    endtask

    // Long image at the widest usable root size, mostly root codes
    task automatic test_table_full();
        send_idle_pct = 35;
        recv_stall_pct = 35;
        write_min_code(11);
        run_image(1'b0, 2100, 92);
        idle_and_drain();
    endtask

    // Long receiver hold-off while words keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_min_code(4);
        hold_req++;
        run_image(1'b0, 60, 50);
        idle_and_drain();
    endtask

    // Receiver ready, with a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_decoded d;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t unexpected word: status %0d pixel %0d",
                         $time, out_if.status, out_if.pixel_index);
                errors++;
            end else begin
                d = decoded_q.pop_front();
                if (out_if.status !== d.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, d.status, out_if.status);
                    errors++;
                end
                if (out_if.pixel_index !== d.pixel) begin
                    $display("%0t pixel_index: expected %0d actual %0d",
                             $time, d.pixel, out_if.pixel_index);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        errors = 0;
        words_sent = 0;
        cycles = 0;
        hold_req = 0;
        hold_ack = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.kind = gld_pkg::KIND_FEED;
        in_if.data_byte = '0;
        out_if.ready = 1'b0;
        lzw_min = gld_pkg::MIN_CODE_RESET;
        lzw_rebuild();
        lzw_start();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_root_sizes();
        test_random();
        test_table_full();
        test_backpressure();

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
